// ----- rtl/core/smlt_pkg.sv -----
// Shared types and constants for the station MAC learning table.
// No dependencies; used by every module in rtl/core.
`default_nettype none
package smlt_pkg;
    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_REJECTED  = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [1:0] CMD_LEARN  = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // One classified request passed from the front to the back.
    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] mac;
        logic [31:0] now;
        logic        rejected;
        logic [31:0] hash;
    } req_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/smlt_front.sv -----
// Front end: accepts words, rejects bad addresses and computes the bucket hash.
// Depends on smlt_pkg.
`default_nettype none
module smlt_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [31:0]    salt,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     in_command,
    input  wire logic [47:0]    in_mac,
    input  wire logic [31:0]    in_time,
    output logic                q_valid,
    input  wire logic           q_ready,
    output smlt_pkg::req_t      q_data
);
    // Two-stage hash: first half of the mix, then the second half.
    logic           s1_valid_reg, s1_valid_next;
    smlt_pkg::req_t s1_req_reg;
    logic [31:0]    s1_a_reg, s1_b_reg, s1_c_reg;
    logic           s2_valid_reg, s2_valid_next;
    smlt_pkg::req_t s2_req_reg;
    logic [31:0]    key, iv, a0, b0, c0, a1, b1, c1, c2, a2, b2, c3;
    logic           adv2, adv1;

    assign key = {in_mac[7:0], in_mac[15:8], in_mac[23:16], in_mac[31:24]};

    // First half of the jhash final mix.
    always_comb begin
        iv = salt + 32'hdeadbeef + 32'd4;
        a0 = key + iv;
        b0 = iv;
        c0 = (iv ^ b0) - smlt_pkg::rotl(b0, 14);
        a1 = (a0 ^ c0) - smlt_pkg::rotl(c0, 11);
        b1 = (b0 ^ a1) - smlt_pkg::rotl(a1, 25);
    end

    // Second half of the mix.
    always_comb begin
        c1 = (s1_c_reg ^ s1_b_reg) - smlt_pkg::rotl(s1_b_reg, 16);
        a2 = (s1_a_reg ^ c1) - smlt_pkg::rotl(c1, 4);
        b2 = (s1_b_reg ^ a2) - smlt_pkg::rotl(a2, 14);
        c2 = (c1 ^ b2) - smlt_pkg::rotl(b2, 24);
        c3 = c2;
    end

    assign adv2 = !s2_valid_reg || q_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign q_valid = s2_valid_reg;
    assign q_data = s2_req_reg;

    always_comb begin
        s1_valid_next = adv1 ? in_valid : s1_valid_reg;
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            s1_req_reg.command  <= in_command;
            s1_req_reg.mac      <= in_mac;
            s1_req_reg.now      <= in_time;
            s1_req_reg.rejected <= (in_mac == 48'd0) || in_mac[40] || in_mac[41];
            s1_req_reg.hash     <= 32'd0;
            s1_a_reg <= a1;
            s1_b_reg <= b1;
            s1_c_reg <= c0;
        end
        if (adv2 && s1_valid_reg) begin
            s2_req_reg <= {s1_req_reg.command, s1_req_reg.mac, s1_req_reg.now,
                           s1_req_reg.rejected, c3};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/smlt_queue.sv -----
// Short two-entry queue between the front and back ends.
// Depends on smlt_pkg.
`default_nettype none
module smlt_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire smlt_pkg::req_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output smlt_pkg::req_t      rd_data
);
    smlt_pkg::req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_wr) wp_reg <= !wp_reg;
            if (do_rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ----- rtl/core/smlt_back.sv -----
// Back end: reads a bucket, decides the command and writes the entry back.
// Depends on smlt_pkg.
`default_nettype none
module smlt_back #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire smlt_pkg::req_t q_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [2:0]          out_status,
    output logic [31:0]         out_stamp,
    output logic [9:0]          out_slot
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW = BW + WW;
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    // Each bucket row holds all of its ways.
    logic [47:0] mac_mem   [BUCKETS][WAYS];
    logic [31:0] stamp_mem [BUCKETS][WAYS];
    logic [WAYS-1:0] valid_mem [BUCKETS];
    logic [47:0] rmac_reg  [WAYS];
    logic [31:0] rstamp_reg[WAYS];
    logic [WAYS-1:0] rvalid_reg;

    logic [1:0]     state_reg, state_next;
    logic [BW-1:0]  clr_reg, clr_next;
    logic           out_valid_reg, out_valid_next;
    logic           take;
    smlt_pkg::req_t req_reg;
    logic [BW-1:0]  bkt_reg;
    logic [BW-1:0]  bkt;
    logic [2:0]     st_reg;
    logic [31:0]    sp_reg;
    logic [9:0]     sl_reg;
    logic [WAYS-1:0] vrow, vrow_new;
    logic           found, have_free;
    logic [WW-1:0]  hit, free_w;
    logic [2:0]     st_n;
    logic [31:0]    sp_n;
    logic [9:0]     sl_n;
    logic           wr_en, wr_clr, wr_set;
    logic [WW-1:0]  wr_way;
    logic [SW-1:0]  base, slot_full;

    assign bkt = BW'(q_data.hash % 32'(BUCKETS));
    // In the idle state a new word is taken once the result register is free or drains now.
    assign q_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign take = q_ready && q_valid;
    assign out_valid = out_valid_reg;
    assign out_status = st_reg;
    assign out_stamp = sp_reg;
    assign out_slot = sl_reg;
    assign vrow = rvalid_reg;

    // Way match and lowest free way.
    always_comb begin
        found = 1'b0;
        have_free = 1'b0;
        hit = '0;
        free_w = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vrow[w]) begin
                if (!found && rmac_reg[w] == req_reg.mac) begin
                    found = 1'b1;
                    hit = WW'(w);
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_w = WW'(w);
            end
        end
    end

    // Command decision.
    always_comb begin
        base = SW'(32'(bkt_reg) * 32'(WAYS));
        slot_full = base + SW'(hit);
        st_n = smlt_pkg::ST_NOT_FOUND;
        sp_n = 32'd0;
        sl_n = 10'(base);
        wr_en = 1'b0;
        wr_clr = 1'b0;
        wr_set = 1'b0;
        wr_way = hit;
        if (req_reg.rejected) begin
            st_n = smlt_pkg::ST_REJECTED;
            sl_n = 10'd0;
        end else if (req_reg.command == smlt_pkg::CMD_LEARN) begin
            if (found) begin
                st_n = smlt_pkg::ST_REFRESHED;
                sp_n = req_reg.now;
                sl_n = 10'(slot_full);
                wr_en = 1'b1;
            end else if (have_free) begin
                st_n = smlt_pkg::ST_NEW;
                sp_n = req_reg.now;
                sl_n = 10'(base + SW'(free_w));
                wr_en = 1'b1;
                wr_set = 1'b1;
                wr_way = free_w;
            end else begin
                st_n = smlt_pkg::ST_FULL;
            end
        end else if (req_reg.command == smlt_pkg::CMD_REMOVE) begin
            if (found) begin
                st_n = smlt_pkg::ST_REMOVED;
                sl_n = 10'(slot_full);
                wr_clr = 1'b1;
            end
        end else if (found) begin
            st_n = smlt_pkg::ST_FOUND;
            sp_n = rstamp_reg[hit];
            sl_n = 10'(slot_full);
        end
    end

    // Updated valid row of the bucket.
    always_comb begin
        vrow_new = vrow;
        if (wr_set) vrow_new[wr_way] = 1'b1;
        if (wr_clr) vrow_new[wr_way] = 1'b0;
    end

    // Sequencer: clearing pass after reset, then read and write-back.
    always_comb begin
        clr_next = clr_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                state_next = (clr_reg == BW'(BUCKETS - 1)) ? S_IDLE : S_CLEAR;
            end
            S_IDLE:  state_next = take ? S_READ : S_IDLE;
            S_READ:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        out_valid_next = (state_reg == S_READ) || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Bucket read, then write-back and result capture.
    always_ff @(posedge aclk) begin
        if (take) begin
            req_reg <= q_data;
            bkt_reg <= bkt;
            rvalid_reg <= valid_mem[bkt];
            for (int w = 0; w < WAYS; w++) begin
                rmac_reg[w]   <= mac_mem[bkt][w];
                rstamp_reg[w] <= stamp_mem[bkt][w];
            end
        end
        if (state_reg == S_CLEAR) begin
            valid_mem[clr_reg] <= '0;
        end else if (state_reg == S_READ) begin
            st_reg <= st_n;
            sp_reg <= sp_n;
            sl_reg <= sl_n;
            if (wr_set || wr_clr) valid_mem[bkt_reg] <= vrow_new;
            if (wr_en) begin
                mac_mem[bkt_reg][wr_way]   <= req_reg.mac;
                stamp_mem[bkt_reg][wr_way] <= req_reg.now;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/station_mac_learning_table.sv -----
// Top level of the station MAC learning table.
// Depends on smlt_pkg, smlt_front, smlt_queue and smlt_back.
//
// Channel  Dir  Contents
// s_       in   command, mac, current_time
// cfg_     in   hash_salt
// m_       out  status, stamp, slot
//
// The front pipelines the hash in halves of the mix and feeds a two-word queue.
// The back reads a bucket, then writes the entry back, before it takes the next word;
// the result register drains while the next word is read.
// Each word passes the front stages, the queue and a bucket read before its result.
// After reset a clearing pass over every bucket empties the valid rows first.
// A stalled m_ side fills the queue and then holds s_tready low.
`default_nettype none
module station_mac_learning_table #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,     // hash_salt
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,      // command[1:0], mac[49:2], current_time[81:50]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata       // status[2:0], stamp[34:3], slot[44:35]
);
    logic [31:0]    salt_reg;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    smlt_pkg::req_t fq_data, qb_data;
    logic [2:0]     st;
    logic [31:0]    sp;
    logic [9:0]     sl;

    assign cfg_ready = 1'b1;
    assign m_tdata = {3'd0, sl, sp, st};

    // Salt register.
    always_ff @(posedge aclk) begin
        if (!aresetn) salt_reg <= 32'd0;
        else if (cfg_valid) salt_reg <= cfg_data;
    end

    smlt_front u_front (
        .aclk, .aresetn, .salt(salt_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_command(s_tdata[1:0]), .in_mac(s_tdata[49:2]), .in_time(s_tdata[81:50]),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    smlt_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    smlt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(st), .out_stamp(sp), .out_slot(sl)
    );
endmodule
`default_nettype wire

// ----- verif/station_mac_learning_table_test.sv -----
// Self-checking testbench for the station MAC learning table.
// Depends on smlt_pkg and station_mac_learning_table; predicts each result word.
`timescale 1ns / 1ps
module station_mac_learning_table_test;
    localparam int BUCKETS = 256;
    localparam int WAYS    = 4;
    localparam int ENTRIES = BUCKETS * WAYS;
    // Unused command code, decoded as a lookup.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] stamp;
        logic [9:0]  slot;
    } station_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    station_mac_learning_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor state: a private copy of the table and the salt.
    logic [31:0] salt_copy;
    logic        table_valid [ENTRIES];
    logic [47:0] table_mac [ENTRIES];
    logic [31:0] table_stamp [ENTRIES];
    station_result_t pending_results[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    logic [47:0] known_macs[$];

    function automatic logic [31:0] rot_left(logic [31:0] v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] bucket_hash(logic [47:0] mac, logic [31:0] salt);
        logic [31:0] key, iv, a, b, c;
        key = {mac[7:0], mac[15:8], mac[23:16], mac[31:24]};
        iv = salt + 32'hdeadbeef + 32'd4;
        a = key + iv;
        b = iv;
        c = iv;
        c ^= b; c -= rot_left(b, 14);
        a ^= c; a -= rot_left(c, 11);
        b ^= a; b -= rot_left(a, 25);
        c ^= b; c -= rot_left(b, 16);
        a ^= c; a -= rot_left(c, 4);
        b ^= a; b -= rot_left(a, 14);
        c ^= b; c -= rot_left(b, 24);
        return c;
    endfunction

    function automatic station_result_t predict_table_op(logic [1:0] cmd, logic [47:0] mac,
                                                         logic [31:0] now);
        station_result_t r;
        int base, hit, free_idx;
        bit found, have_free;
        found = 0;
        have_free = 0;
        hit = 0;
        free_idx = 0;
        if (mac == 48'd0 || mac[40] || mac[41]) begin
            r = '{smlt_pkg::ST_REJECTED, 32'd0, 10'd0};
            return r;
        end
        base = (bucket_hash(mac, salt_copy) % BUCKETS) * WAYS;
        for (int w = 0; w < WAYS; w++) begin
            if (table_valid[base + w]) begin
                if (!found && table_mac[base + w] == mac) begin
                    found = 1;
                    hit = base + w;
                end
            end else if (!have_free) begin
                have_free = 1;
                free_idx = base + w;
            end
        end
        if (cmd == smlt_pkg::CMD_LEARN) begin
            if (found) begin
                table_stamp[hit] = now;
                r = '{smlt_pkg::ST_REFRESHED, now, hit[9:0]};
            end else if (have_free) begin
                table_valid[free_idx] = 1'b1;
                table_mac[free_idx] = mac;
                table_stamp[free_idx] = now;
                r = '{smlt_pkg::ST_NEW, now, free_idx[9:0]};
            end else begin
                r = '{smlt_pkg::ST_FULL, 32'd0, base[9:0]};
            end
        end else if (cmd == smlt_pkg::CMD_REMOVE) begin
            if (found) begin
                table_valid[hit] = 1'b0;
                r = '{smlt_pkg::ST_REMOVED, 32'd0, hit[9:0]};
            end else begin
                r = '{smlt_pkg::ST_NOT_FOUND, 32'd0, base[9:0]};
            end
        end else begin
            // Lookup, and the unused code that decodes as one.
            if (found) r = '{smlt_pkg::ST_FOUND, table_stamp[hit], hit[9:0]};
            else r = '{smlt_pkg::ST_NOT_FOUND, 32'd0, base[9:0]};
        end
        return r;
    endfunction

    // Send one command word, idling beforehand at the current rate.
    task automatic send_word(logic [1:0] cmd, logic [47:0] mac, logic [31:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, now, mac, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_table_op(cmd, mac, now));
        if (mac != 0 && !mac[40] && !mac[41]) known_macs.push_back(mac);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result word with the oldest expectation.
    always @(posedge aclk) begin
        station_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[34:3], m_tdata[44:35]};
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.stamp !== want.stamp) begin
                    $error("stamp expected %h actual %h", want.stamp, got.stamp);
                    fail_count++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot expected %0d actual %0d", want.slot, got.slot);
                    fail_count++;
                end
            end
        end
    end

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_salt(logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        salt_copy = value;
        known_macs.delete();
    endtask

    // Unicast, globally administered address with a random body.
    function automatic logic [47:0] station_mac();
        logic [47:0] m;
        m = 48'({$urandom, $urandom});
        m[41:40] = 2'b00;
        if (m == 0) m[47] = 1'b1;
        return m;
    endfunction

    // Addresses sharing a bucket, to fill it past its ways.
    function automatic logic [47:0] mac_in_bucket(int bucket);
        logic [47:0] m;
        do m = station_mac();
        while ((bucket_hash(m, salt_copy) % BUCKETS) != bucket);
        return m;
    endfunction

    task automatic test_directed();
        logic [47:0] m;
        send_word(smlt_pkg::CMD_LEARN, 48'd0, 32'hffffffff);
        send_word(smlt_pkg::CMD_LOOKUP, 48'h010000000001, 32'd0);
        send_word(smlt_pkg::CMD_REMOVE, 48'h020000000001, 32'd0);
        send_word(smlt_pkg::CMD_LEARN, 48'hffffffffffff, 32'd1);
        send_word(smlt_pkg::CMD_LEARN, 48'hfcffffffffff, 32'hffffffff);
        send_word(smlt_pkg::CMD_LEARN, 48'h000000000001, 32'd0);
        send_word(smlt_pkg::CMD_LEARN, 48'hfcffffffffff, 32'h12345678);
        send_word(smlt_pkg::CMD_LOOKUP, 48'hfcffffffffff, 32'd0);
        send_word(CMD_SPARE, 48'h000000000001, 32'd0);
        send_word(smlt_pkg::CMD_REMOVE, 48'hfcffffffffff, 32'd0);
        send_word(smlt_pkg::CMD_REMOVE, 48'hfcffffffffff, 32'd0);
        send_word(smlt_pkg::CMD_LOOKUP, 48'hfcffffffffff, 32'd0);
        // Fill one bucket and go one beyond it.
        for (int i = 0; i < WAYS + 1; i++) begin
            m = mac_in_bucket(7);
            send_word(smlt_pkg::CMD_LEARN, m, $urandom);
        end
        send_word(smlt_pkg::CMD_LOOKUP, mac_in_bucket(7), 32'd0);
    endtask

    task automatic test_random(int count, int bucket_bias);
        logic [47:0] m;
        logic [1:0] cmd;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                m = 48'({$urandom, $urandom});
            end else if (pick < 50 && known_macs.size() != 0) begin
                m = known_macs[$urandom_range(known_macs.size() - 1)];
            end else if (pick < 50 + bucket_bias) begin
                m = mac_in_bucket(int'($urandom_range(3)));
            end else begin
                m = station_mac();
            end
            cmd = 2'($urandom_range(3));
            if ($urandom_range(1)) cmd = smlt_pkg::CMD_LEARN;
            send_word(cmd, m, $urandom);
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 300;
        test_random(40, 10);
        drain_results();
    endtask

    initial begin
        salt_copy = '0;
        for (int i = 0; i < ENTRIES; i++) table_valid[i] = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_salt(32'hffffffff);
        test_random(250, 20);
        send_idle_pct = 67;
        write_salt($urandom);
        test_random(250, 20);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        write_salt(32'd0);
        test_random(250, 20);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        write_salt($urandom);
        test_random(280, 20);
        test_backpressure();
        drain_results();
        if (fail_count == 0) begin
            $display("PASS station_mac_learning_table");
        end else begin
            $display("FAIL station_mac_learning_table");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL station_mac_learning_table");
        $finish;
    end
endmodule

// ----- station_mac_learning_table.f -----
rtl/core/smlt_pkg.sv
rtl/core/smlt_front.sv
rtl/core/smlt_queue.sv
rtl/core/smlt_back.sv
rtl/core/station_mac_learning_table.sv
verif/station_mac_learning_table_test.sv
